// File: design/apu_fs_pkg.sv
// Shared types and constants for the audio frame sequencer.
// No dependencies; imported by every module of the block.
package apu_fs_pkg;

    localparam int REG_COUNT   = 8;
    localparam int CFG_INDEX_W = $clog2(REG_COUNT);
    localparam int CFG_WIDTH   = 16;
    localparam int COUNT_W     = 16;
    localparam int DELAY_W     = 3;

    typedef logic [CFG_WIDTH-1:0] cfg_word_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [DELAY_W-1:0]   delay_t;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_MODE_WRITE = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_ONE   = 3'd0,
        REG_STEP_TWO   = 3'd1,
        REG_STEP_THREE = 3'd2,
        REG_STEP_FOUR  = 3'd3,
        REG_POST_FOUR  = 3'd4,
        REG_STEP_FIVE  = 3'd5,
        REG_FOUR_LEN   = 3'd6,
        REG_FIVE_LEN   = 3'd7
    } reg_idx_t;

    localparam cfg_word_t CFG_RESET [REG_COUNT] = '{
        16'd7457, 16'd14913, 16'd22371, 16'd29829,
        16'd29830, 16'd37281, 16'd29830, 16'd37282
    };

    localparam delay_t DELAY_ODD  = 3'd3;
    localparam delay_t DELAY_EVEN = 3'd4;

    typedef struct packed {
        logic quarter_pulse;
        logic half_pulse;
        logic frame_irq;
        logic irq_set_now;
    } result_t;

endpackage

// File: design/apu_fs_core.sv
// Sequencer core: configuration registers, sequencer state and the
// combinational step logic. Depends on apu_fs_pkg.
module apu_fs_core
    import apu_fs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  cfg_word_t              cfg_data,
    input  logic                   step,
    input  logic [1:0]             command,
    input  logic                   new_mode,
    input  logic                   new_inhibit,
    input  logic                   odd_cycle,
    output result_t                result
);

    cfg_word_t cfg_reg [REG_COUNT];

    count_t cycle_count_reg, cycle_count_next;
    logic   seq_mode_reg, seq_mode_next;
    logic   irq_inhibit_reg, irq_inhibit_next;
    logic   change_pending_reg, change_pending_next;
    delay_t change_delay_reg, change_delay_next;
    logic   pending_mode_reg, pending_mode_next;
    logic   pending_inhibit_reg, pending_inhibit_next;
    logic   irq_flag_reg, irq_flag_next;

    count_t base_count;
    count_t cnt;
    logic   qp, hp, set_now;
    logic   raise;
    logic   wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        cycle_count_next     = cycle_count_reg;
        seq_mode_next        = seq_mode_reg;
        irq_inhibit_next     = irq_inhibit_reg;
        change_pending_next  = change_pending_reg;
        change_delay_next    = change_delay_reg;
        pending_mode_next    = pending_mode_reg;
        pending_inhibit_next = pending_inhibit_reg;
        irq_flag_next        = irq_flag_reg;
        base_count           = cycle_count_reg;
        cnt                  = '0;
        qp                   = 1'b0;
        hp                   = 1'b0;
        set_now              = 1'b0;
        raise                = 1'b0;
        wrap                 = 1'b0;

        unique case (cmd_t'(command))
            CMD_TICK:
            begin
                // pending mode change counts down and applies first
                if (change_pending_reg && (change_delay_reg != '0))
                begin
                    change_delay_next = change_delay_reg - 1'b1;
                    if (change_delay_reg == delay_t'(1))
                    begin
                        change_pending_next = 1'b0;
                        seq_mode_next       = pending_mode_reg;
                        irq_inhibit_next    = pending_inhibit_reg;
                        if (pending_inhibit_reg)
                        begin
                            irq_flag_next = 1'b0;
                        end
                        base_count = '0;
                        qp         = pending_mode_reg;
                        hp         = pending_mode_reg;
                    end
                end

                cnt = base_count + 1'b1;

                priority if (cnt == cfg_reg[REG_STEP_ONE])
                begin
                    qp = 1'b1;
                end
                else if (cnt == cfg_reg[REG_STEP_TWO])
                begin
                    qp = 1'b1;
                    hp = 1'b1;
                end
                else if (cnt == cfg_reg[REG_STEP_THREE])
                begin
                    qp = 1'b1;
                end
                else if (cnt == cfg_reg[REG_STEP_FOUR])
                begin
                    if (!seq_mode_next)
                    begin
                        qp    = 1'b1;
                        hp    = 1'b1;
                        raise = 1'b1;
                    end
                end
                else if (cnt == cfg_reg[REG_POST_FOUR])
                begin
                    raise = !seq_mode_next;
                end
                else if (cnt == cfg_reg[REG_STEP_FIVE])
                begin
                    if (seq_mode_next)
                    begin
                        qp = 1'b1;
                        hp = 1'b1;
                    end
                end

                if (raise && !irq_inhibit_next)
                begin
                    irq_flag_next = 1'b1;
                    set_now       = 1'b1;
                end

                wrap = seq_mode_next ? (cnt >= cfg_reg[REG_FIVE_LEN])
                                     : (cnt >= cfg_reg[REG_FOUR_LEN]);
                cycle_count_next = wrap ? '0 : cnt;
            end
            CMD_MODE_WRITE:
            begin
                pending_mode_next    = new_mode;
                pending_inhibit_next = new_inhibit;
                change_pending_next  = 1'b1;
                change_delay_next    = odd_cycle ? DELAY_ODD : DELAY_EVEN;
                if (new_inhibit)
                begin
                    irq_flag_next = 1'b0;
                end
            end
            CMD_CLEAR:
            begin
                irq_flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        result.quarter_pulse = qp;
        result.half_pulse    = hp;
        result.frame_irq     = irq_flag_next;
        result.irq_set_now   = set_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg     <= '0;
            seq_mode_reg        <= 1'b0;
            irq_inhibit_reg     <= 1'b0;
            change_pending_reg  <= 1'b0;
            change_delay_reg    <= '0;
            pending_mode_reg    <= 1'b0;
            pending_inhibit_reg <= 1'b0;
            irq_flag_reg        <= 1'b0;
        end
        else if (step)
        begin
            cycle_count_reg     <= cycle_count_next;
            seq_mode_reg        <= seq_mode_next;
            irq_inhibit_reg     <= irq_inhibit_next;
            change_pending_reg  <= change_pending_next;
            change_delay_reg    <= change_delay_next;
            pending_mode_reg    <= pending_mode_next;
            pending_inhibit_reg <= pending_inhibit_next;
            irq_flag_reg        <= irq_flag_next;
        end
    end

endmodule

// File: design/apu_frame_sequencer.sv
// Top level of the audio frame sequencer: core plus a two-entry result buffer.
// Depends on apu_fs_pkg and apu_fs_core.
//
// One command per transaction, one result per transaction. While in_stall
// is low a command is taken every cycle; its result is registered in the
// output register, or in a second register that absorbs one stalled result,
// and the core state updates in the same cycle, so ticks run back to back
// at one per clock. in_stall rises only once both result registers are full;
// it is a registered signal with no path from out_stall. Configuration writes
// are applied at once and should be made only while no command is in flight.
module apu_frame_sequencer
    import apu_fs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic                   new_mode,
    input  logic                   new_inhibit,
    input  logic                   odd_cycle,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   quarter_pulse,
    output logic                   half_pulse,
    output logic                   frame_irq,
    output logic                   irq_set_now
);

    logic    push, pop;
    result_t step_result;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign in_stall = skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign pop      = head_valid_reg && !out_stall;

    apu_fs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (push),
        .command     (command),
        .new_mode    (new_mode),
        .new_inhibit (new_inhibit),
        .odd_cycle   (odd_cycle),
        .result      (step_result)
    );

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = step_result;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = step_result;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = step_result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = head_valid_reg;
    assign quarter_pulse = head_reg.quarter_pulse;
    assign half_pulse    = head_reg.half_pulse;
    assign frame_irq     = head_reg.frame_irq;
    assign irq_set_now   = head_reg.irq_set_now;

endmodule

// File: design/apu_fs_checker.sv
// Port-level checks for apu_frame_sequencer, bound to the top level.
// Depends on apu_fs_pkg and apu_frame_sequencer.
module apu_fs_checker
    import apu_fs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic quarter_pulse,
    input logic half_pulse,
    input logic frame_irq,
    input logic irq_set_now
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(quarter_pulse)
            && $stable(half_pulse) && $stable(frame_irq) && $stable(irq_set_now))
        else $error("stalled result changed");

    // input side only stalls once a result is waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_half_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && half_pulse |-> quarter_pulse)
        else $error("half pulse without quarter pulse");

    a_set_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_set_now |-> frame_irq)
        else $error("interrupt set but flag low");

endmodule

bind apu_frame_sequencer apu_fs_checker u_apu_fs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .quarter_pulse (quarter_pulse),
    .half_pulse    (half_pulse),
    .frame_irq     (frame_irq),
    .irq_set_now   (irq_set_now)
);

// File: sim/frame_seq_checker.sv
// Checker for the audio frame sequencer: follows register writes and both channels,
// predicts one result per command and compares it with what the block returns.
// Depends on apu_fs_pkg.
module frame_seq_checker
    import apu_fs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             command,
    input  logic                   new_mode,
    input  logic                   new_inhibit,
    input  logic                   odd_cycle,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   quarter_pulse,
    input  logic                   half_pulse,
    input  logic                   frame_irq,
    input  logic                   irq_set_now,
    output int                     mismatches,
    output int                     outstanding
);

    cfg_word_t step_regs [REG_COUNT];
    count_t    cycle_cnt;
    logic      five_step;
    logic      inhibit;
    logic      change_armed;
    delay_t    change_wait;
    logic      next_five_step;
    logic      next_inhibit;
    logic      irq_level;

    result_t   results_due [$];

    function automatic result_t sequence_command(cmd_t cmd, logic mode_req, logic inh_req,
                                                 logic odd);
        result_t r;
        r = '0;
        case (cmd)
            CMD_TICK:
            begin
                if (change_armed && change_wait != 0)
                begin
                    change_wait = change_wait - 1'b1;
                    if (change_wait == 0)
                    begin
                        change_armed = 1'b0;
                        five_step    = next_five_step;
                        inhibit      = next_inhibit;
                        if (inhibit)
                            irq_level = 1'b0;
                        cycle_cnt = '0;
                        if (five_step)
                        begin
                            r.quarter_pulse = 1'b1;
                            r.half_pulse    = 1'b1;
                        end
                    end
                end
                cycle_cnt = cycle_cnt + 1'b1;
                // first matching step wins
                if (cycle_cnt == step_regs[REG_STEP_ONE])
                    r.quarter_pulse = 1'b1;
                else if (cycle_cnt == step_regs[REG_STEP_TWO])
                begin
                    r.quarter_pulse = 1'b1;
                    r.half_pulse    = 1'b1;
                end
                else if (cycle_cnt == step_regs[REG_STEP_THREE])
                    r.quarter_pulse = 1'b1;
                else if (cycle_cnt == step_regs[REG_STEP_FOUR])
                begin
                    if (!five_step)
                    begin
                        r.quarter_pulse = 1'b1;
                        r.half_pulse    = 1'b1;
                        if (!inhibit)
                        begin
                            irq_level     = 1'b1;
                            r.irq_set_now = 1'b1;
                        end
                    end
                end
                else if (cycle_cnt == step_regs[REG_POST_FOUR])
                begin
                    if (!five_step && !inhibit)
                    begin
                        irq_level     = 1'b1;
                        r.irq_set_now = 1'b1;
                    end
                end
                else if (cycle_cnt == step_regs[REG_STEP_FIVE])
                begin
                    if (five_step)
                    begin
                        r.quarter_pulse = 1'b1;
                        r.half_pulse    = 1'b1;
                    end
                end
                if ((!five_step && cycle_cnt >= step_regs[REG_FOUR_LEN]) ||
                    (five_step && cycle_cnt >= step_regs[REG_FIVE_LEN]))
                    cycle_cnt = '0;
            end
            CMD_MODE_WRITE:
            begin
                next_five_step = mode_req;
                next_inhibit   = inh_req;
                change_armed   = 1'b1;
                change_wait    = odd ? DELAY_ODD : DELAY_EVEN;
                if (inh_req)
                    irq_level = 1'b0;
            end
            CMD_CLEAR:
                irq_level = 1'b0;
            default:
                ;
        endcase
        r.frame_irq = irq_level;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                step_regs[i] = CFG_RESET[i];
            cycle_cnt      = '0;
            five_step      = 1'b0;
            inhibit        = 1'b0;
            change_armed   = 1'b0;
            change_wait    = '0;
            next_five_step = 1'b0;
            next_inhibit   = 1'b0;
            irq_level      = 1'b0;
            results_due.delete();
            mismatches     = 0;
            outstanding    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {quarter_pulse, half_pulse, frame_irq, irq_set_now};
                if (results_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected transaction: q%b h%b irq%b set%b",
                                 got.quarter_pulse, got.half_pulse, got.frame_irq,
                                 got.irq_set_now);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: exp q%b h%b irq%b set%b got q%b h%b irq%b set%b",
                                     want.quarter_pulse, want.half_pulse, want.frame_irq,
                                     want.irq_set_now, got.quarter_pulse, got.half_pulse,
                                     got.frame_irq, got.irq_set_now);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                step_regs[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
                results_due.push_back(sequence_command(cmd_t'(command), new_mode,
                                                       new_inhibit, odd_cycle));
            outstanding = results_due.size();
        end
    end

endmodule

// File: sim/testbench.sv
// Top of the frame sequencer testbench: clock, reset, register setup and command stimulus
// with random idling on both channels; the verdict comes from frame_seq_checker.
// Depends on apu_fs_pkg, apu_frame_sequencer and frame_seq_checker.
module testbench;
    import apu_fs_pkg::*;

    localparam int LONG_HOLD = 150;
    localparam int IDLE_LIMIT = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]   cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             command;
    logic                   new_mode;
    logic                   new_inhibit;
    logic                   odd_cycle;
    logic                   out_valid;
    logic                   out_stall;
    logic                   quarter_pulse;
    logic                   half_pulse;
    logic                   frame_irq;
    logic                   irq_set_now;

    int        mismatches;
    int        outstanding;
    int        idle_cycles;
    bit        calm;
    bit        no_gaps;
    bit        long_hold_req;
    cfg_word_t cfg_plan [REG_COUNT];

    apu_frame_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .new_mode      (new_mode),
        .new_inhibit   (new_inhibit),
        .odd_cycle     (odd_cycle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quarter_pulse (quarter_pulse),
        .half_pulse    (half_pulse),
        .frame_irq     (frame_irq),
        .irq_set_now   (irq_set_now)
    );

    frame_seq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .new_mode      (new_mode),
        .new_inhibit   (new_inhibit),
        .odd_cycle     (odd_cycle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quarter_pulse (quarter_pulse),
        .half_pulse    (half_pulse),
        .frame_irq     (frame_irq),
        .irq_set_now   (irq_set_now),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold on request
    initial
    begin
        int  n;
        bit  hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                hold = ($urandom_range(0, 2) == 0);
                n    = $urandom_range(1, 11);
                out_stall <= hold;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    task automatic send_cmd(input cmd_t cmd, input logic m, input logic inh, input logic odd);
        int n;
        if (!calm && !no_gaps && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        new_mode    <= m;
        new_inhibit <= inh;
        odd_cycle   <= odd;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random;
        int   r;
        cmd_t cmd;
        r = $urandom_range(0, 99);
        if (r < 78)
            cmd = CMD_TICK;
        else if (r < 88)
            cmd = CMD_MODE_WRITE;
        else if (r < 96)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_NOP;
        send_cmd(cmd, ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                 ($urandom_range(0, 1) == 1));
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random();
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_regs;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= cfg_plan[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic plan_ordered(input int step_max);
        int s;
        s = 0;
        for (int i = REG_STEP_ONE; i <= REG_STEP_FIVE; i++)
        begin
            s = s + $urandom_range(1, step_max);
            cfg_plan[i] = cfg_word_t'(s);
        end
        cfg_plan[REG_FOUR_LEN] = cfg_plan[REG_POST_FOUR];
        cfg_plan[REG_FIVE_LEN] = cfg_plan[REG_STEP_FIVE] + 1'b1;
    endtask

    task automatic plan_scattered;
        for (int i = 0; i < REG_COUNT; i++)
            cfg_plan[i] = cfg_word_t'($urandom_range(1, 40));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_TICK;
        new_mode      = 1'b0;
        new_inhibit   = 1'b0;
        odd_cycle     = 1'b0;
        calm          = 1'b0;
        no_gaps       = 1'b0;
        long_hold_req = 1'b0;
        idle_cycles   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: full four-step sequence, clear, mode changes with both delays
        cfg_plan = '{16'd2, 16'd4, 16'd6, 16'd8, 16'd9, 16'd10, 16'd9, 16'd11};
        load_regs();
        repeat (9) send_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_cmd(CMD_NOP, 1'b0, 1'b0, 1'b0);
        send_cmd(CMD_CLEAR, 1'b0, 1'b0, 1'b0);
        repeat (8) send_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_cmd(CMD_MODE_WRITE, 1'b1, 1'b1, 1'b1);
        repeat (3) send_cmd(CMD_TICK, 1'b1, 1'b1, 1'b1);
        send_cmd(CMD_MODE_WRITE, 1'b0, 1'b0, 1'b0);
        send_cmd(CMD_MODE_WRITE, 1'b1, 1'b0, 1'b1);
        repeat (4) send_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_cmd(CMD_NOP, 1'b1, 1'b1, 1'b1);
        drain();

        plan_ordered(6);
        load_regs();
        run_random(180);
        drain();

        // every register at 1: equal steps, counter wraps on every tick
        for (int i = 0; i < REG_COUNT; i++)
            cfg_plan[i] = 16'd1;
        load_regs();
        run_random(100);
        drain();

        plan_scattered();
        load_regs();
        run_random(80);
        drain();
        run_random(80);
        drain();

        // steps out of reach, short sequences
        for (int i = REG_STEP_ONE; i <= REG_STEP_FIVE; i++)
            cfg_plan[i] = 16'hFFFF;
        cfg_plan[REG_FOUR_LEN] = cfg_word_t'($urandom_range(5, 30));
        cfg_plan[REG_FIVE_LEN] = cfg_word_t'($urandom_range(5, 30));
        load_regs();
        run_random(120);
        drain();

        // lengths at their maximum
        plan_ordered(8);
        cfg_plan[REG_FOUR_LEN] = 16'hFFFF;
        cfg_plan[REG_FIVE_LEN] = 16'hFFFF;
        load_regs();
        run_random(120);
        drain();

        plan_scattered();
        load_regs();
        run_random(40);
        long_hold_req = 1'b1;
        no_gaps       = 1'b1;
        run_random(50);
        no_gaps = 1'b0;
        run_random(60);
        calm = 1'b1;
        run_random(100);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
